[src/floyd_warshall_all_pairs_assert.svh]
// Assertion macros for the Floyd-Warshall engine sequencer.
`ifndef FLOYD_WARSHALL_ALL_PAIRS_ASSERT_SVH
`define FLOYD_WARSHALL_ALL_PAIRS_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define FWAP_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwap assertion failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define FWAP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwap assertion failed: next-cycle implication");

`else

`define FWAP_ASSERT_IMPL(name, clk, rst, ante, cons)
`define FWAP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[src/fwap_pkg.sv]
// Shared types, constants and saturation helpers for the Floyd-Warshall engine.
package fwap_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int DIST_WIDTH   = 48;

   localparam int IDX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W    = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int ENTRY_W  = DIST_WIDTH + 1;

   // Fixed field widths
   localparam int CMD_W    = 2;
   localparam int VIDX_W   = 6;
   localparam int FIELD_W  = 48;
   localparam int VC_W     = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   // CSR map (word index)
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
   localparam logic [VC_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic signed [63:0] DIST_MAX  = (64'sd1 <<< (DIST_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] DIST_MIN  = -DIST_MAX - 64'sd1;
   localparam logic signed [63:0] FIELD_MAX = (64'sd1 <<< (FIELD_W - 1)) - 64'sd1;
   localparam logic signed [63:0] FIELD_MIN = -FIELD_MAX - 64'sd1;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [VIDX_W-1:0]         row;
      logic [VIDX_W-1:0]         col;
      logic signed [FIELD_W-1:0] weight;
      logic                      weight_infinite;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] distance;
      logic                      distance_infinite;
      logic                      negative_cycle;
   } rsp_type;

   // Controller -> datapath
   typedef struct packed {
      logic take;       // write/read/unused item transferred
      logic start_run;  // run item transferred, clear counters
      logic rd_pair;    // read (i,k) and (k,j)
      logic rd_ij;      // read (i,j), form candidate
      logic update;     // compare and write back, advance j/i/k
      logic rd_diag;    // read (i,i)
      logic chk_diag;   // check diagonal entry, advance i
      logic finish;     // commit flag, emit run result
   } dp_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic empty;
      logic last_j;
      logic last_i;
      logic last_k;
   } dp_status_type;

   function automatic logic [DIST_WIDTH-1:0] clamp_weight(input logic signed [FIELD_W-1:0] w);
      logic signed [63:0] v;
      v = 64'(w);
      if (v > DIST_MAX) begin
         return DIST_WIDTH'(DIST_MAX);
      end else if (v < DIST_MIN) begin
         return DIST_WIDTH'(DIST_MIN);
      end
      return DIST_WIDTH'(v);
   endfunction

   function automatic logic [FIELD_W-1:0] clamp_field(input logic signed [DIST_WIDTH-1:0] d);
      logic signed [63:0] v;
      v = 64'(d);
      if (v > FIELD_MAX) begin
         return FIELD_W'(FIELD_MAX);
      end else if (v < FIELD_MIN) begin
         return FIELD_W'(FIELD_MIN);
      end
      return FIELD_W'(v);
   endfunction

   function automatic logic [DIST_WIDTH-1:0] sat_add(input logic [DIST_WIDTH-1:0] a,
                                                     input logic [DIST_WIDTH-1:0] b);
      logic [DIST_WIDTH:0] s;
      s = {a[DIST_WIDTH-1], a} + {b[DIST_WIDTH-1], b};
      if (s[DIST_WIDTH] != s[DIST_WIDTH-1]) begin
         return s[DIST_WIDTH] ? {1'b1, {(DIST_WIDTH-1){1'b0}}} : {1'b0, {(DIST_WIDTH-1){1'b1}}};
      end
      return s[DIST_WIDTH-1:0];
   endfunction

endpackage

[src/fwap_ram.sv]
// Generic RAM: one write port, two registered read ports.
module fwap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/fwap_ctrl.sv]
// Sequencer for the relaxation and diagonal scan of the Floyd-Warshall engine.
`include "floyd_warshall_all_pairs_assert.svh"

module fwap_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fwap_pkg::CMD_W-1:0]   command,
   input  fwap_pkg::dp_status_type      status,
   output logic                         busy,
   output fwap_pkg::dp_cmd_type         cmd
);

   import fwap_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      RELAX_LOAD,
      RELAX_SUM,
      RELAX_UPDATE,
      DIAG_READ,
      DIAG_CHECK,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      cmd           = '0;
      cmd.take      = accept && (command != CMD_RUN);
      cmd.start_run = accept && (command == CMD_RUN);
      case (state_ff)
         IDLE: begin
            if (cmd.start_run) begin
               busy_in  = 1'b1;
               state_in = status.empty ? FINISH : RELAX_LOAD;
            end
         end
         RELAX_LOAD: begin
            cmd.rd_pair = 1'b1;
            state_in    = RELAX_SUM;
         end
         RELAX_SUM: begin
            cmd.rd_ij = 1'b1;
            state_in  = RELAX_UPDATE;
         end
         RELAX_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = (status.last_k && status.last_i && status.last_j) ? DIAG_READ
                                                                            : RELAX_LOAD;
         end
         DIAG_READ: begin
            cmd.rd_diag = 1'b1;
            state_in    = DIAG_CHECK;
         end
         DIAG_CHECK: begin
            cmd.chk_diag = 1'b1;
            state_in     = status.last_i ? FINISH : DIAG_READ;
         end
         FINISH: begin
            cmd.finish = 1'b1;
            busy_in    = 1'b0;
            state_in   = IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   `FWAP_ASSERT_NEXT(a_run_sets_busy, clock, reset, cmd.start_run, busy_ff)
   `FWAP_ASSERT_IMPL(a_update_follows_sum, clock, reset, cmd.update, $past(cmd.rd_ij))
   `FWAP_ASSERT_NEXT(a_finish_frees, clock, reset, cmd.finish, !busy_ff && !cmd.update)

endmodule

[src/fwap_datapath.sv]
// Matrix store, loop counters, saturating relax unit and result register.
module fwap_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  fwap_pkg::dp_cmd_type        cmd,
   output fwap_pkg::dp_status_type     status,
   input  fwap_pkg::req_type           req_data,
   input  logic [fwap_pkg::VC_W-1:0]   vertex_count,
   output logic                        rsp_strobe,
   output fwap_pkg::rsp_type           rsp_data
);

   import fwap_pkg::*;

   logic [CNT_W-1:0]      n_vert;
   logic [IDX_W-1:0]      last_idx;
   logic [IDX_W-1:0]      k_ff, i_ff, j_ff;
   logic [IDX_W-1:0]      k_in, i_in, j_in;
   logic                  acc_ff, acc_in;
   logic                  cycle_found_ff, cycle_found_in;
   logic [DIST_WIDTH-1:0] cand_ff, cand_in;
   logic                  cand_ok_ff, cand_ok_in;
   logic                  s1_valid_ff;
   logic [CMD_W-1:0]      s1_cmd_ff;
   logic                  s1_in_range_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  in_range;
   logic [ADDR_W-1:0]     req_addr;
   logic [ADDR_W-1:0]     rd_addr_a, rd_addr_b, wr_addr;
   logic [ENTRY_W-1:0]    rd_data_a, rd_data_b, wr_data;
   logic                  wr_en;
   logic                  a_inf, b_inf;
   logic [DIST_WIDTH-1:0] a_val, b_val;
   logic                  better;

   always_comb begin
      if (32'(vertex_count) > MAX_VERTICES) begin
         n_vert = CNT_W'(MAX_VERTICES);
      end else begin
         n_vert = CNT_W'(vertex_count);
      end
   end

   assign last_idx = IDX_W'(n_vert - CNT_W'(1));

   assign status.empty  = (n_vert == '0);
   assign status.last_j = (j_ff == last_idx);
   assign status.last_i = (i_ff == last_idx);
   assign status.last_k = (k_ff == last_idx);

   assign in_range = (32'(req_data.row) < MAX_VERTICES) && (32'(req_data.col) < MAX_VERTICES);
   assign req_addr = {IDX_W'(req_data.row), IDX_W'(req_data.col)};

   assign a_inf = rd_data_a[DIST_WIDTH];
   assign a_val = rd_data_a[DIST_WIDTH-1:0];
   assign b_inf = rd_data_b[DIST_WIDTH];
   assign b_val = rd_data_b[DIST_WIDTH-1:0];

   // In the update phase port A returns (i,j)
   assign better = cand_ok_ff && (a_inf || ($signed(cand_ff) < $signed(a_val)));

   always_comb begin
      if (cmd.rd_pair) begin
         rd_addr_a = {i_ff, k_ff};
      end else if (cmd.rd_ij) begin
         rd_addr_a = {i_ff, j_ff};
      end else if (cmd.rd_diag) begin
         rd_addr_a = {i_ff, i_ff};
      end else begin
         rd_addr_a = req_addr;
      end
      rd_addr_b = {k_ff, j_ff};
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_addr;
      wr_data = '0;
      if (cmd.update) begin
         wr_en   = better;
         wr_addr = {i_ff, j_ff};
         wr_data = {1'b0, cand_ff};
      end else if (cmd.take && (req_data.command == CMD_WRITE) && in_range) begin
         wr_en   = 1'b1;
         wr_data = req_data.weight_infinite ? {1'b1, {DIST_WIDTH{1'b0}}}
                                            : {1'b0, clamp_weight(req_data.weight)};
      end
   end

   fwap_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Loop counters: j innermost, then i, then k; all wrap to zero at the end
   always_comb begin
      k_in = k_ff;
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.start_run) begin
         k_in = '0;
         i_in = '0;
         j_in = '0;
      end else if (cmd.update) begin
         if (status.last_j) begin
            j_in = '0;
            if (status.last_i) begin
               i_in = '0;
               k_in = status.last_k ? '0 : k_ff + IDX_W'(1);
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end else if (cmd.chk_diag) begin
         i_in = status.last_i ? '0 : i_ff + IDX_W'(1);
      end
   end

   always_comb begin
      cand_in    = cand_ff;
      cand_ok_in = cand_ok_ff;
      if (cmd.rd_ij) begin
         cand_in    = sat_add(a_val, b_val);
         cand_ok_in = !a_inf && !b_inf;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start_run) begin
         acc_in = 1'b0;
      end else if (cmd.chk_diag && !a_inf && a_val[DIST_WIDTH-1]) begin
         acc_in = 1'b1;
      end
      cycle_found_in = cmd.finish ? acc_ff : cycle_found_ff;
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.finish) begin
         rsp_in.negative_cycle = acc_ff;
      end else begin
         rsp_in.negative_cycle = cycle_found_ff;
         if (s1_cmd_ff == CMD_READ) begin
            if (!s1_in_range_ff || a_inf) begin
               rsp_in.distance_infinite = 1'b1;
            end else begin
               rsp_in.distance = clamp_field(a_val);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff           <= '0;
         i_ff           <= '0;
         j_ff           <= '0;
         acc_ff         <= 1'b0;
         cycle_found_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         k_ff           <= k_in;
         i_ff           <= i_in;
         j_ff           <= j_in;
         acc_ff         <= acc_in;
         cycle_found_ff <= cycle_found_in;
         s1_valid_ff    <= cmd.take;
         rsp_valid_ff   <= s1_valid_ff || cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff        <= cand_in;
      cand_ok_ff     <= cand_ok_in;
      s1_cmd_ff      <= req_data.command;
      s1_in_range_ff <= in_range;
      rsp_ff         <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

[src/floyd_warshall_all_pairs.sv]
// Top level of the Floyd-Warshall all-pairs shortest-path engine.
// Write, read and unused commands: one transfer per cycle while busy is low, result strobe
//   registered through the s1 stage and the result register.
// Run command: busy while it runs (n = vertex_count clipped to 64; n = 0 skips the relax and
//   the diagonal scan), result strobe in the same cycle in which busy returns low; each relax
//   step runs as read, add and write back through the single write port of the matrix RAM.
// Reset (synchronous): clears busy, the result strobe and the negative-cycle flag, and loads
//   vertex_count with 64; the distance matrix is not cleared.
module floyd_warshall_all_pairs (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              start,
   output logic                              busy,
   input  fwap_pkg::req_type                 req_data,
   // result channel, cannot be stalled
   output logic                              rsp_strobe,
   output fwap_pkg::rsp_type                 rsp_data,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fwap_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fwap_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fwap_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   import fwap_pkg::*;

   logic [VC_W-1:0] vertex_count_ff, vertex_count_in;
   logic            csr_sel_vc;
   dp_cmd_type      dp_cmd;
   dp_status_type   dp_status;

   // Single register at word 0; higher words read as zero and ignore writes.
   assign csr_sel_vc = (paddr[CSR_ADDR_W-1:2] == REG_VERTEX_COUNT);
   assign pready     = 1'b1;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (psel && penable && pwrite && pready && csr_sel_vc) begin
         vertex_count_in = pwdata[VC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign prdata = csr_sel_vc ? CSR_DATA_W'(vertex_count_ff) : '0;

   // Sequencer: accepts items, steps the relax loop (k outer, i, j inner) and
   // the diagonal scan, and tells the datapath when to report a run.
   fwap_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_data.command),
      .status  (dp_status),
      .busy    (busy),
      .cmd     (dp_cmd)
   );

   // Datapath: matrix RAM, loop counters, saturating add/compare, flag and
   // the two-stage result path for writes, reads and unused commands.
   fwap_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (dp_cmd),
      .status       (dp_status),
      .req_data     (req_data),
      .vertex_count (vertex_count_ff),
      .rsp_strobe   (rsp_strobe),
      .rsp_data     (rsp_data)
   );

endmodule

[tb/sv/fwap_checker.sv]
// Result checker for the Floyd-Warshall engine: shadow matrix, prediction and comparison.
module fwap_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  fwap_pkg::req_type                     req_data,
   input  logic                                  rsp_strobe,
   input  fwap_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fwap_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [fwap_pkg::CSR_DATA_W-1:0]       pwdata,
   input  logic [fwap_pkg::CSR_DATA_W-1:0]       prdata,
   input  logic                                  pready,
   output int                                    mismatches,
   output int                                    outstanding
);
   import fwap_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] VC_ADDR = CSR_ADDR_W'(4 * REG_VERTEX_COUNT);
   localparam int REPORT_LIMIT = 100;

   // shadow of the engine state
   logic signed [DIST_WIDTH-1:0] dist_val [DEPTH];
   bit                           dist_inf [DEPTH];
   bit                           cycle_flag = 1'b0;
   logic [VC_W-1:0]              vertex_count_q = VERTEX_COUNT_RESET;

   rsp_type pending_rsp [$];
   int      fail_count = 0;
   int      pending = 0;

   assign mismatches  = fail_count;
   assign outstanding = pending;

   task automatic flag_mismatch(input string what, input logic signed [63:0] want_v,
                                input logic signed [63:0] got_v);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
      end else if (fail_count == REPORT_LIMIT + 1) begin
         $display("%0t: further mismatches not shown", $time);
      end
   endtask

   // in-place relaxation, k outer, then diagonal scan for a negative cycle
   task automatic relax_matrix();
      int     n;
      int     ik;
      int     kj;
      int     ij;
      longint cand;
      n = (vertex_count_q > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_q);
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < n; i++) begin
            ik = i * MAX_VERTICES + k;
            if (dist_inf[ik]) continue;
            for (int j = 0; j < n; j++) begin
               kj = k * MAX_VERTICES + j;
               ij = i * MAX_VERTICES + j;
               if (dist_inf[kj]) continue;
               cand = longint'(dist_val[ik]) + longint'(dist_val[kj]);
               if (cand > DIST_MAX) cand = DIST_MAX;
               else if (cand < DIST_MIN) cand = DIST_MIN;
               if (dist_inf[ij] || cand < longint'(dist_val[ij])) begin
                  dist_val[ij] = DIST_WIDTH'(cand);
                  dist_inf[ij] = 1'b0;
               end
            end
         end
      end
      cycle_flag = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!dist_inf[i * MAX_VERTICES + i] && dist_val[i * MAX_VERTICES + i] < 0)
            cycle_flag = 1'b1;
      end
   endtask

   task automatic predict_command(input req_type item);
      rsp_type want;
      int      idx;
      longint  v;
      want = '0;
      idx  = int'(item.row) * MAX_VERTICES + int'(item.col);
      case (item.command)
         CMD_WRITE: begin
            // 48-bit field into a 48-bit entry: saturation is the identity here
            dist_inf[idx] = item.weight_infinite;
            dist_val[idx] = item.weight_infinite ? '0 : item.weight;
         end
         CMD_RUN: relax_matrix();
         CMD_READ: begin
            if (dist_inf[idx]) begin
               want.distance_infinite = 1'b1;
            end else begin
               v = longint'(dist_val[idx]);
               if (v > FIELD_MAX) v = FIELD_MAX;
               else if (v < FIELD_MIN) v = FIELD_MIN;
               want.distance = FIELD_W'(v);
            end
         end
         default: ;  // unused code: no state change, answers like a write
      endcase
      want.negative_cycle = cycle_flag;
      pending_rsp.push_back(want);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         flag_mismatch("result with nothing pending, distance", 0, got.distance);
         return;
      end
      want = pending_rsp.pop_front();
      if (got.distance !== want.distance)
         flag_mismatch("distance", want.distance, got.distance);
      if (got.distance_infinite !== want.distance_infinite)
         flag_mismatch("distance_infinite", want.distance_infinite, got.distance_infinite);
      if (got.negative_cycle !== want.negative_cycle)
         flag_mismatch("negative_cycle", want.negative_cycle, got.negative_cycle);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cycle_flag     = 1'b0;
         vertex_count_q = VERTEX_COUNT_RESET;
         pending_rsp.delete();
      end else begin
         if (psel && penable && pready && paddr == VC_ADDR) begin
            if (pwrite) begin
               vertex_count_q = pwdata[VC_W-1:0];
            end else if (prdata !== CSR_DATA_W'(vertex_count_q)) begin
               flag_mismatch("vertex_count readback", vertex_count_q, prdata);
            end
         end
         // compare first: a result never belongs to the transfer of the same edge
         if (rsp_strobe) check_result(rsp_data);
         if (start && !busy) predict_command(req_data);
      end
      pending = pending_rsp.size();
   end

endmodule

[tb/sv/floyd_warshall_all_pairs_tb.sv]
// Testbench top for the Floyd-Warshall engine: clock, reset, command stimulus and verdict.
module floyd_warshall_all_pairs_tb;
   import fwap_pkg::*;

   // command 3 has no package name; the engine treats it as a no-op
   localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] VC_ADDR    = CSR_ADDR_W'(4 * REG_VERTEX_COUNT);
   localparam int CLOCK_HALF = 6;
   localparam int PHASE_COUNT = 12;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   req_type                 req_data = '0;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int mismatches;
   int outstanding;

   // entries written so far: reads and runs only touch these
   bit written [DEPTH];
   int side = MAX_VERTICES;     // vertex_count as the engine applies it
   bit gaps_on = 1'b1;          // random sender idling
   bit allow_negative = 1'b1;   // negative weights in random writes
   int n_writes = 0;
   int n_reads = 0;
   int n_runs = 0;
   int n_other = 0;

   int phase_size [PHASE_COUNT] = '{3, 1, 8, 5, 0, 2, 6, 4, 7, 8, 3, 5};

   floyd_warshall_all_pairs DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   fwap_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Hard stop: far beyond what the whole test needs (runs stay at eight vertices or fewer).
   initial begin
      #(CLOCK_HALF * 2 * 6_000_000);
      $display("end of test: mismatches");
      $finish;
   end

   // Weight mix: half small positive, some negative, the saturation extremes, full random.
   function automatic logic signed [FIELD_W-1:0] rand_weight();
      logic signed [FIELD_W-1:0] w;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: w = FIELD_W'($urandom_range(0, 40));
         10:      w = -FIELD_W'($urandom_range(1, 15));
         11:      w = FIELD_W'(DIST_MAX);
         12:      w = FIELD_W'(DIST_MIN);
         13:      w = FIELD_W'(DIST_MAX) - FIELD_W'($urandom_range(0, 100));
         14:      w = FIELD_W'(DIST_MIN) + FIELD_W'($urandom_range(0, 100));
         15, 16:  w = FIELD_W'({$urandom(), $urandom()});
         default: w = FIELD_W'($urandom_range(1000, 1_000_000));
      endcase
      if (!allow_negative && w < 0)
         w = (w == FIELD_W'(DIST_MIN)) ? FIELD_W'(DIST_MAX) : -w;
      return w;
   endfunction

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drive one command at the falling edge; it transfers at the first rising edge with busy low.
   // start stays high into the next command when no gap follows.
   task automatic issue_command(input req_type item);
      if (gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      case (item.command)
         CMD_WRITE: begin
            written[int'(item.row) * MAX_VERTICES + int'(item.col)] = 1'b1;
            n_writes++;
         end
         CMD_RUN:  n_runs++;
         CMD_READ: n_reads++;
         default:  n_other++;
      endcase
   endtask

   task automatic write_entry(input logic [VIDX_W-1:0] r, input logic [VIDX_W-1:0] c,
                              input logic signed [FIELD_W-1:0] w, input logic inf);
      req_type item;
      item.command         = CMD_WRITE;
      item.row             = r;
      item.col             = c;
      item.weight          = w;
      item.weight_infinite = inf;
      issue_command(item);
   endtask

   // Reads, runs and unused commands carry random junk in the fields they ignore.
   task automatic other_command(input logic [CMD_W-1:0] code, input logic [VIDX_W-1:0] r,
                                input logic [VIDX_W-1:0] c);
      req_type item;
      item.command         = code;
      item.row             = r;
      item.col             = c;
      item.weight          = FIELD_W'({$urandom(), $urandom()});
      item.weight_infinite = $urandom_range(0, 1);
      issue_command(item);
   endtask

   task automatic run_relax();
      other_command(CMD_RUN, VIDX_W'($urandom_range(0, 63)), VIDX_W'($urandom_range(0, 63)));
   endtask

   // Hold the sender until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [VC_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = is_write;
      paddr   = VC_ADDR;
      // upper bits are junk the register must ignore
      pwdata  = ($urandom() & ~CSR_DATA_W'(7'h7f)) | CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Only while idle: drain, then reconfigure.
   task automatic set_size(input logic [VC_W-1:0] value);
      drain_results();
      csr_access(1'b1, value);
      side = (value > MAX_VERTICES) ? MAX_VERTICES : int'(value);
      if ($urandom_range(0, 1) == 0) csr_access(1'b0, '0);
   endtask

   // Load every entry in use, so a run never touches an unwritten one.
   task automatic fill_matrix();
      for (int i = 0; i < side; i++) begin
         for (int j = 0; j < side; j++) begin
            if (i == j) begin
               write_entry(VIDX_W'(i), VIDX_W'(j),
                           ($urandom_range(0, 9) == 0) ? rand_weight() : '0,
                           $urandom_range(0, 11) == 0);
            end else begin
               write_entry(VIDX_W'(i), VIDX_W'(j), rand_weight(), $urandom_range(0, 9) < 3);
            end
         end
      end
   endtask

   // A read target that has been written: mostly inside the active square.
   task automatic pick_written(output logic [VIDX_W-1:0] r, output logic [VIDX_W-1:0] c);
      int idx;
      r = '0;
      c = '0;
      if (side > 0 && $urandom_range(0, 9) < 6) begin
         r = VIDX_W'($urandom_range(0, side - 1));
         c = VIDX_W'($urandom_range(0, side - 1));
         return;
      end
      repeat (16) begin
         idx = $urandom_range(0, DEPTH - 1);
         if (written[idx]) begin
            r = VIDX_W'(idx / MAX_VERTICES);
            c = VIDX_W'(idx % MAX_VERTICES);
            return;
         end
      end
      // entry (0,0) is written in the directed part
   endtask

   task automatic random_phase(input int count);
      int                sel;
      logic [VIDX_W-1:0] r;
      logic [VIDX_W-1:0] c;
      for (int t = 0; t < count; t++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            if (side > 0 && $urandom_range(0, 1) == 0) begin
               r = VIDX_W'($urandom_range(0, side - 1));
               c = VIDX_W'($urandom_range(0, side - 1));
            end else begin
               r = VIDX_W'($urandom_range(0, 63));
               c = VIDX_W'($urandom_range(0, 63));
            end
            write_entry(r, c, rand_weight(), $urandom_range(0, 4) == 0);
         end else if (sel < 80) begin
            pick_written(r, c);
            other_command(CMD_READ, r, c);
         end else if (sel < 90) begin
            run_relax();
         end else if (sel < 96) begin
            other_command(CMD_UNUSED, VIDX_W'($urandom_range(0, 63)),
                          VIDX_W'($urandom_range(0, 63)));
         end else if (gaps_on) begin
            drain_results();  // sender holds until the engine is empty
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed: field extremes at the reset size (64), no runs yet ----
      write_entry(6'd0, 6'd0, FIELD_W'(DIST_MAX), 1'b0);
      other_command(CMD_READ, 6'd0, 6'd0);
      write_entry(6'd63, 6'd63, FIELD_W'(DIST_MIN), 1'b0);
      other_command(CMD_READ, 6'd63, 6'd63);
      write_entry(6'd0, 6'd63, '1, 1'b1);              // infinity, weight bits ignored
      other_command(CMD_READ, 6'd0, 6'd63);
      write_entry(6'd63, 6'd0, -FIELD_W'(1), 1'b0);
      other_command(CMD_READ, 6'd63, 6'd0);
      // unused command with random field bits must leave (63,0) alone
      write_entry(6'd63, 6'd0, -FIELD_W'(1), 1'b0);
      other_command(CMD_UNUSED, 6'd63, 6'd0);
      other_command(CMD_READ, 6'd63, 6'd0);
      drain_results();
      csr_access(1'b0, '0);

      // two vertices: saturating sums, then a negative cycle
      set_size(7'd2);
      write_entry(6'd0, 6'd0, '0, 1'b0);
      write_entry(6'd0, 6'd1, FIELD_W'(DIST_MAX), 1'b0);
      write_entry(6'd1, 6'd0, FIELD_W'(5), 1'b0);
      write_entry(6'd1, 6'd1, '0, 1'b0);
      run_relax();
      other_command(CMD_READ, 6'd0, 6'd1);
      write_entry(6'd1, 6'd0, FIELD_W'(DIST_MIN), 1'b0);
      run_relax();
      other_command(CMD_READ, 6'd1, 6'd1);

      // zero vertices: the run relaxes nothing and clears the flag
      set_size(7'd0);
      run_relax();
      other_command(CMD_READ, 6'd1, 6'd1);

      // one vertex with an infinite diagonal
      set_size(7'd1);
      write_entry(6'd0, 6'd0, FIELD_W'({$urandom(), $urandom()}), 1'b1);
      run_relax();
      other_command(CMD_READ, 6'd0, 6'd0);

      // ---- random phases on small sizes, each with a fresh matrix ----
      for (int p = 0; p < PHASE_COUNT; p++) begin
         gaps_on        = (p % 4 != 3);
         allow_negative = (p % 3 != 1);
         set_size(VC_W'(phase_size[p]));
         fill_matrix();
         random_phase(70);
      end

      // ---- register extreme 127: written and read back, plus reads of known entries ----
      gaps_on        = 1'b1;
      allow_negative = 1'b1;
      set_size(7'd127);
      csr_access(1'b0, '0);
      other_command(CMD_READ, 6'd0, 6'd0);
      other_command(CMD_READ, 6'd63, 6'd63);

      // ---- closing stretch, back-to-back transfers ----
      gaps_on = 1'b0;
      set_size(7'd6);
      fill_matrix();
      random_phase(60);

      drain_results();
      repeat (8) @(negedge clock);

      $display("covered %0d writes, %0d reads, %0d runs, %0d unused commands",
               n_writes, n_reads, n_runs, n_other);
      $display("sizes 0 to 8 under random traffic, saturation extremes, size register up to 127");
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/fwap_pkg.sv
src/fwap_ram.sv
src/fwap_ctrl.sv
src/fwap_datapath.sv
src/floyd_warshall_all_pairs.sv
tb/sv/fwap_checker.sv
tb/sv/floyd_warshall_all_pairs_tb.sv
